[rtl/psf_pkg.sv]
// Package: shared types, constants and helpers for the polygon scanline fill unit.
package psf_pkg;

   localparam int MaxVertices  = 16;
   localparam int MaxCrossings = 15;
   localparam int MaxSurfDim   = 4096;
   localparam int VtxIdxW      = $clog2(MaxVertices);
   localparam int VtxCntW      = $clog2(MaxVertices + 1);
   localparam int XingIdxW     = $clog2(MaxCrossings);
   localparam int XingCntW     = $clog2(MaxCrossings + 1);
   localparam int QueueDepth   = 2;
   localparam int QueueIdxW    = $clog2(QueueDepth);
   localparam int QueueCntW    = $clog2(QueueDepth + 1);

   localparam logic [1:0] CsrSurfaceWidth  = 2'd0;
   localparam logic [1:0] CsrSurfaceHeight = 2'd1;
   localparam logic [1:0] CsrFillColor     = 2'd2;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusTooFew   = 2'd1;
   localparam logic [1:0] StatusTooMany  = 2'd2;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
   } req_type;

   typedef struct packed {
      logic [11:0] span_row;
      logic [11:0] span_left;
      logic [11:0] span_right;
      logic        span_valid;
      logic        row_last;
      logic        polygon_done;
      logic [1:0]  status;
      logic [31:0] color_argb;
   } rsp_type;

   // Command from the front end to the back end.
   typedef struct packed {
      logic               is_row;   // 1: rasterize row, 0: emit a single marker
      logic [1:0]         status;
      logic               done;
      logic [12:0]        row;
      logic [VtxCntW-1:0] count;
   } cmd_type;

   function automatic logic [12:0] cap_dim(input logic [12:0] d);
      if (d > 13'(MaxSurfDim)) return 13'(MaxSurfDim);
      return d;
   endfunction

endpackage

[rtl/polygon_scanline_fill_unit.sv]
// Top level of the polygon scanline fill unit.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   input   | start, busy, req_item                   | accepted when start & !busy
//   result  | rsp_strobe, rsp_item                    | one cycle per result
//   config  | csr_write, csr_index, csr_data          | written when csr_write
//
// A vertex item is stored directly. An advance item walks every edge,
// runs the shift-subtract divider once per crossing, then the sort and
// the pairing of crossings into spans; the first row of a polygon also
// scans every vertex for the y range.
// Reset is synchronous and clears the state machines and the queue; results cannot be stalled.
module polygon_scanline_fill_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  psf_pkg::req_type req_item,
   output logic             rsp_strobe,
   output psf_pkg::rsp_type rsp_item,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import psf_pkg::*;

   logic [12:0]        width_ff, height_ff;
   logic [31:0]        color_ff;
   logic               q_push, q_pop, q_full, q_empty, back_busy;
   cmd_type            q_in, q_head;
   logic [VtxIdxW-1:0] rd_idx;
   logic signed [15:0] rd_x, rd_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         color_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrSurfaceWidth:  width_ff  <= csr_data[12:0];
            CsrSurfaceHeight: height_ff <= csr_data[12:0];
            CsrFillColor:     color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   psf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_item),
      .surf_h      (height_ff),
      .q_full      (q_full),
      .vtx_rd_busy (back_busy),
      .busy        (busy),
      .q_push      (q_push),
      .q_cmd       (q_in),
      .rd_idx      (rd_idx),
      .rd_x        (rd_x),
      .rd_y        (rd_y)
   );

   psf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   psf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .surf_w     (width_ff),
      .color      (color_ff),
      .rd_idx     (rd_idx),
      .rd_x       (rd_x),
      .rd_y       (rd_y),
      .busy       (back_busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );
endmodule

[rtl/psf_div.sv]
// Sequential signed divider, truncating toward zero, one quotient bit per cycle.
module psf_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [47:0]  dividend,
   input  logic signed [16:0]  divisor,
   output logic                busy,
   output logic signed [47:0]  quotient
);
   import psf_pkg::*;

   logic [47:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [16:0] den_ff, den_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [48:0] trial;
   logic [47:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      shifted = '0;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[47] ? 48'(-dividend) : dividend;
         den_in  = divisor[16] ? 17'(-divisor) : divisor;
         neg_in  = dividend[47] ^ divisor[16];
         busy_in = 1'b1;
         cnt_in  = 6'd48;
      end else if (busy_ff) begin
         shifted = {rem_ff[46:0], quo_ff[47]};
         trial   = {1'b0, shifted} - {32'b0, den_ff};
         quo_in  = {quo_ff[46:0], ~trial[48]};
         rem_in  = trial[48] ? shifted : trial[47:0];
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? 48'(-quo_ff) : quo_ff;
endmodule

[rtl/psf_front.sv]
// Front end: vertex storage, polygon state and per-item classification.
module psf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  psf_pkg::req_type          req,
   input  logic [12:0]               surf_h,
   input  logic                      q_full,
   input  logic                      vtx_rd_busy,
   output logic                      busy,
   output logic                      q_push,
   output psf_pkg::cmd_type          q_cmd,
   input  logic [psf_pkg::VtxIdxW-1:0] rd_idx,
   output logic signed [15:0]        rd_x,
   output logic signed [15:0]        rd_y
);
   import psf_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_SCAN = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   logic signed [15:0] vx_mem [MaxVertices];
   logic signed [15:0] vy_mem [MaxVertices];

   fstate_type         st_ff, st_in;
   logic [VtxCntW-1:0] cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in, act_ff, act_in;
   logic [12:0]        row_ff, row_in, fin_ff, fin_in;
   logic [VtxIdxW-1:0] sc_ff, sc_in;
   logic signed [15:0] ymin_ff, ymin_in, ymax_ff, ymax_in;
   cmd_type            cmd_ff, cmd_in;
   logic               accept, wr_vtx;
   logic signed [15:0] sy;
   logic [12:0]        h;
   logic signed [16:0] lo_c, hi_c;

   assign accept = start && !busy;
   assign wr_vtx = accept && !req.kind && (act_ff || cnt_ff < VtxCntW'(MaxVertices));
   assign busy   = (st_ff != F_IDLE) || vtx_rd_busy;
   assign sy     = vy_mem[sc_ff];
   assign h      = cap_dim(surf_h);

   always_ff @(posedge clock) begin
      if (wr_vtx) begin
         vx_mem[act_ff ? '0 : cnt_ff[VtxIdxW-1:0]] <= req.vertex_x;
         vy_mem[act_ff ? '0 : cnt_ff[VtxIdxW-1:0]] <= req.vertex_y;
      end
   end

   assign rd_x = vx_mem[rd_idx];
   assign rd_y = vy_mem[rd_idx];

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      act_in  = act_ff;
      row_in  = row_ff;
      fin_in  = fin_ff;
      sc_in   = sc_ff;
      ymin_in = ymin_ff;
      ymax_in = ymax_ff;
      cmd_in  = cmd_ff;
      q_push  = 1'b0;
      lo_c    = (ymin_ff < 0) ? 17'sd0 : 17'(ymin_ff);
      hi_c    = (17'(ymax_ff) >= $signed({4'b0, h})) ? $signed({4'b0, h}) - 17'sd1
                                                    : 17'(ymax_ff);
      unique case (st_ff)
         F_IDLE: begin
            if (accept && !req.kind) begin
               if (act_ff) begin
                  act_in = 1'b0;
                  ovf_in = 1'b0;
                  cnt_in = VtxCntW'(1);
               end else if (cnt_ff < VtxCntW'(MaxVertices)) begin
                  cnt_in = cnt_ff + VtxCntW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (accept) begin
               cmd_in = '0;
               cmd_in.count = cnt_ff;
               if (act_ff) begin
                  cmd_in.is_row = 1'b1;
                  cmd_in.row    = row_ff;
                  cmd_in.done   = (row_ff >= fin_ff);
                  if (row_ff >= fin_ff) begin
                     act_in = 1'b0;
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end else begin
                     row_in = row_ff + 13'd1;
                  end
                  st_in = F_PUSH;
               end else if (ovf_ff || cnt_ff < VtxCntW'(3)) begin
                  cmd_in.status = ovf_ff ? StatusTooMany : StatusTooFew;
                  cmd_in.done   = 1'b1;
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  st_in  = F_PUSH;
               end else begin
                  sc_in   = '0;
                  ymin_in = 16'sh7fff;
                  ymax_in = -16'sh8000;
                  st_in   = F_SCAN;
               end
            end
         end
         F_SCAN: begin
            if (sy < ymin_ff) ymin_in = sy;
            if (sy > ymax_ff) ymax_in = sy;
            sc_in = sc_ff + VtxIdxW'(1);
            if (VtxCntW'(sc_ff) + VtxCntW'(1) == cnt_ff) begin
               st_in = F_PUSH;
               ymin_in = (sy < ymin_ff) ? sy : ymin_ff;
               ymax_in = (sy > ymax_ff) ? sy : ymax_ff;
               cmd_in  = '0;
               cmd_in.count = cnt_ff;
            end
         end
         F_PUSH: begin
            if (!cmd_ff.is_row && cmd_ff.status == StatusOk && !cmd_ff.done) begin
               // min/max just finished: decide range
               if (lo_c > hi_c) begin
                  cmd_in.done = 1'b1;
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  cmd_in.is_row = 1'b1;
                  cmd_in.row    = 13'(lo_c);
                  cmd_in.done   = (lo_c >= hi_c);
                  fin_in        = 13'(hi_c);
                  if (lo_c >= hi_c) begin
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end else begin
                     act_in = 1'b1;
                     row_in = 13'(lo_c) + 13'd1;
                  end
               end
            end else if (!q_full) begin
               q_push = 1'b1;
               st_in  = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   assign q_cmd = cmd_ff;

   always_ff @(posedge clock) begin
      ymin_ff <= ymin_in;
      ymax_ff <= ymax_in;
      cmd_ff  <= cmd_in;
      sc_ff   <= sc_in;
      if (reset) begin
         st_ff  <= F_IDLE;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         act_ff <= 1'b0;
         row_ff <= '0;
         fin_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         act_ff <= act_in;
         row_ff <= row_in;
         fin_ff <= fin_in;
      end
   end
endmodule

[rtl/psf_queue.sv]
// Short command queue between the front and back ends.
module psf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psf_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output psf_pkg::cmd_type head
);
   import psf_pkg::*;

   cmd_type              mem_ff [QueueDepth];
   logic [QueueIdxW-1:0] wp_ff, rp_ff;
   logic [QueueCntW-1:0] n_ff;

   assign full  = (n_ff == QueueCntW'(QueueDepth));
   assign empty = (n_ff == '0);
   assign head  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= push_cmd;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         if (push && !full) wp_ff <= wp_ff + QueueIdxW'(1);
         if (pop && !empty) rp_ff <= rp_ff + QueueIdxW'(1);
         n_ff <= n_ff + QueueCntW'(push && !full) - QueueCntW'(pop && !empty);
      end
   end
endmodule

[rtl/psf_back.sv]
// Back end: edge crossings with a serial divider, insertion sort, span pairing.
module psf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  psf_pkg::cmd_type            q_head,
   output logic                        q_pop,
   input  logic [12:0]                 surf_w,
   input  logic [31:0]                 color,
   output logic [psf_pkg::VtxIdxW-1:0] rd_idx,
   input  logic signed [15:0]          rd_x,
   input  logic signed [15:0]          rd_y,
   output logic                        busy,
   output logic                        rsp_strobe,
   output psf_pkg::rsp_type            rsp
);
   import psf_pkg::*;

   typedef enum logic [7:0] {
      B_IDLE  = 8'b00000001,
      B_EDGEA = 8'b00000010,
      B_EDGEB = 8'b00000100,
      B_MUL   = 8'b00001000,
      B_DIV   = 8'b00010000,
      B_SORT  = 8'b00100000,
      B_EMIT  = 8'b01000000,
      B_LAST  = 8'b10000000
   } bstate_type;

   bstate_type          st_ff, st_in;
   cmd_type             cmd_ff, cmd_in;
   logic [VtxIdxW-1:0]  ei_ff, ei_in;
   logic signed [15:0]  xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic signed [47:0]  prod_ff, prod_in;
   logic signed [47:0]  xs_ff [MaxCrossings];
   logic signed [47:0]  xs_in [MaxCrossings];
   logic [XingCntW-1:0] nx_ff, nx_in, sa_ff, sa_in, sb_ff, sb_in, pa_ff, pa_in;
   logic                any_ff, any_in;
   logic                div_start, div_busy, div_busy_d;
   logic signed [47:0]  quo;
   logic signed [16:0]  den;
   logic [VtxIdxW-1:0]  nxt;
   logic signed [16:0]  yrow;
   logic signed [16:0]  lo, hi;
   logic signed [16:0]  dx, dy;
   logic signed [33:0]  prod_w;
   logic signed [48:0]  l, r, t, wlim;
   logic                span_ok, last_pair;
   rsp_type             rsp_in, rsp_ff;
   logic                strobe_in, strobe_ff;

   psf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign nxt  = (VtxCntW'(ei_ff) + VtxCntW'(1) == cmd_ff.count) ? '0 : ei_ff + VtxIdxW'(1);
   assign rd_idx = (st_ff == B_EDGEA) ? ei_ff : nxt;
   assign yrow = $signed({4'b0, cmd_ff.row});
   assign lo   = (ya_ff < yb_ff) ? 17'(ya_ff) : 17'(yb_ff);
   assign hi   = (ya_ff < yb_ff) ? 17'(yb_ff) : 17'(ya_ff);
   assign den  = 17'(yb_ff) - 17'(ya_ff);
   assign dx   = 17'(xb_ff) - 17'(xa_ff);
   assign dy   = yrow - 17'(ya_ff);
   assign prod_w = dx * dy;
   assign wlim = $signed({36'b0, cap_dim(surf_w)}) - 49'sd1;
   assign busy = (st_ff != B_IDLE) || !q_empty;

   always_comb begin
      l = 49'(xs_ff[pa_ff[XingIdxW-1:0]]);
      r = 49'(xs_ff[pa_ff[XingIdxW-1:0] + XingIdxW'(1)]);
      if (l > r) begin
         t = l; l = r; r = t;
      end else begin
         t = '0;
      end
      if (l < 0) l = '0;
      if (r > wlim) r = wlim;
      span_ok   = (l <= r);
      // crossings are sorted: a next left edge past the right clip ends the row
      last_pair = (pa_ff + XingCntW'(3) >= nx_ff) ||
                  (49'(xs_ff[pa_ff[XingIdxW-1:0] + XingIdxW'(2)]) > wlim);
   end

   always_comb begin
      st_in     = st_ff;
      cmd_in    = cmd_ff;
      ei_in     = ei_ff;
      xa_in     = xa_ff;
      ya_in     = ya_ff;
      xb_in     = xb_ff;
      yb_in     = yb_ff;
      prod_in   = prod_ff;
      nx_in     = nx_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      pa_in     = pa_ff;
      any_in    = any_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = '0;
      rsp_in.color_argb = {color[7:0], color[31:8]};
      for (int k = 0; k < MaxCrossings; k++) xs_in[k] = xs_ff[k];
      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               ei_in  = '0;
               nx_in  = '0;
               any_in = 1'b0;
               st_in  = q_head.is_row ? B_EDGEA : B_LAST;
            end
         end
         B_EDGEA: begin
            xa_in = rd_x;
            ya_in = rd_y;
            st_in = B_EDGEB;
         end
         B_EDGEB: begin
            xb_in = rd_x;
            yb_in = rd_y;
            st_in = B_MUL;
         end
         B_MUL: begin
            prod_in = 48'(prod_w);
            if (ya_ff == yb_ff || yrow < lo || yrow >= hi) begin
               if (nxt == '0) begin
                  st_in = B_SORT;
                  sa_in = XingCntW'(1);
                  sb_in = XingCntW'(1);
               end else begin
                  ei_in = nxt;
                  st_in = B_EDGEA;
               end
            end else begin
               st_in = B_DIV;
            end
         end
         B_DIV: begin
            if (!div_busy && !div_busy_d) begin
               div_start = 1'b1;
            end
            st_in = B_DIV;
         end
         B_SORT: begin
            if (sa_ff >= nx_ff) begin
               pa_in = '0;
               st_in = B_EMIT;
            end else if (sb_ff != '0 &&
                         xs_ff[sb_ff[XingIdxW-1:0] - XingIdxW'(1)] >
                         xs_ff[sb_ff[XingIdxW-1:0]]) begin
               xs_in[sb_ff[XingIdxW-1:0] - XingIdxW'(1)] = xs_ff[sb_ff[XingIdxW-1:0]];
               xs_in[sb_ff[XingIdxW-1:0]] = xs_ff[sb_ff[XingIdxW-1:0] - XingIdxW'(1)];
               sb_in = sb_ff - XingCntW'(1);
            end else begin
               sa_in = sa_ff + XingCntW'(1);
               sb_in = sa_ff + XingCntW'(1);
            end
         end
         B_EMIT: begin
            if (pa_ff + XingCntW'(1) >= nx_ff) begin
               st_in = B_LAST;
            end else begin
               pa_in = pa_ff + XingCntW'(2);
               if (span_ok) begin
                  strobe_in         = 1'b1;
                  any_in            = 1'b1;
                  rsp_in.span_row   = cmd_ff.row[11:0];
                  rsp_in.span_left  = l[11:0];
                  rsp_in.span_right = r[11:0];
                  rsp_in.span_valid = 1'b1;
                  if (last_pair) begin
                     rsp_in.row_last     = 1'b1;
                     rsp_in.polygon_done = cmd_ff.done;
                     st_in = B_IDLE;
                  end
               end
            end
         end
         B_LAST: begin
            if (!any_ff) begin
               strobe_in           = 1'b1;
               rsp_in.span_row     = cmd_ff.is_row ? cmd_ff.row[11:0] : 12'd0;
               rsp_in.row_last     = 1'b1;
               rsp_in.polygon_done = cmd_ff.done;
               rsp_in.status       = cmd_ff.status;
            end
            st_in = B_IDLE;
         end
         default: st_in = B_IDLE;
      endcase
      // divider completion; started division always finishes in B_DIV
      if (st_ff == B_DIV && div_busy_d) begin
         if (!div_busy) begin
            xs_in[nx_ff[XingIdxW-1:0]] = 48'(xa_ff) + quo;
            nx_in = nx_ff + XingCntW'(1);
            if (nxt == '0 || nx_ff + XingCntW'(1) == XingCntW'(MaxCrossings)) begin
               st_in = B_SORT;
               sa_in = XingCntW'(1);
               sb_in = XingCntW'(1);
            end else begin
               ei_in = nxt;
               st_in = B_EDGEA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) div_busy_d <= 1'b0;
      else       div_busy_d <= div_busy;
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      ei_ff   <= ei_in;
      xa_ff   <= xa_in;
      ya_ff   <= ya_in;
      xb_ff   <= xb_in;
      yb_ff   <= yb_in;
      prod_ff <= prod_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      pa_ff   <= pa_in;
      rsp_ff  <= rsp_in;
      for (int k = 0; k < MaxCrossings; k++) xs_ff[k] <= xs_in[k];
      if (reset) begin
         st_ff     <= B_IDLE;
         nx_ff     <= '0;
         any_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         nx_ff     <= nx_in;
         any_ff    <= any_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
endmodule
